// File: hdl/i2cmbe_pkg.sv
// Package with shared types and constants of the I2C master bit engine.
package i2cmbe_pkg;

    localparam int CFG_W      = 12;
    localparam int BYTE_W     = 8;
    localparam int ACTION_W   = 3;
    localparam int BIT_IDX_W  = 4;
    localparam int PHASE_W    = 5;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_W-1:0] DELAY_RESET = 12'd250;

    // Command codes
    localparam logic [ACTION_W-1:0] ACT_NONE   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_START  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_ACK    = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_WAIT   = 3'd6;

    // Bits per byte and index of the most significant bit
    localparam logic [BIT_IDX_W-1:0] BITS_PER_BYTE = 4'd8;
    localparam int                   MSB_POS       = 7;

    typedef struct packed {
        logic                sda_in;
        logic                ack_level;
        logic [BYTE_W-1:0]   tx_byte;
        logic [ACTION_W-1:0] action;
    } item_t;

    typedef struct packed {
        logic              nack_seen;
        logic [BYTE_W-1:0] rx_byte;
        logic              done_res;
        logic              busy_res;
        logic              sda_output_enable;
        logic              sda_level;
        logic              scl_level;
    } result_t;

endpackage

// File: hdl/i2cmbe_seq.sv
// Pin sequencer state and the next-state logic for one tick.
module i2cmbe_seq #(
    parameter int DELAY_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  logic [i2cmbe_pkg::CFG_W-1:0]  delay_ticks,
    input  i2cmbe_pkg::item_t             item,
    output i2cmbe_pkg::result_t           result
);
    import i2cmbe_pkg::*;

    localparam logic [PHASE_W-1:0] PH_IDLE     = 5'd0;
    localparam logic [PHASE_W-1:0] PH_ST_HIGH  = 5'd1;
    localparam logic [PHASE_W-1:0] PH_ST_LOW   = 5'd2;
    localparam logic [PHASE_W-1:0] PH_SP_LOW   = 5'd3;
    localparam logic [PHASE_W-1:0] PH_SP_HIGH  = 5'd4;
    localparam logic [PHASE_W-1:0] PH_WA_HIGH  = 5'd5;
    localparam logic [PHASE_W-1:0] PH_WA_LOW   = 5'd6;
    localparam logic [PHASE_W-1:0] PH_WS_LOW   = 5'd7;
    localparam logic [PHASE_W-1:0] PH_WS_HIGH  = 5'd8;
    localparam logic [PHASE_W-1:0] PH_AK_LOW   = 5'd9;
    localparam logic [PHASE_W-1:0] PH_AK_HIGH  = 5'd10;
    localparam logic [PHASE_W-1:0] PH_TX_SETUP = 5'd11;
    localparam logic [PHASE_W-1:0] PH_TX_DATA  = 5'd12;
    localparam logic [PHASE_W-1:0] PH_TX_HIGH  = 5'd13;
    localparam logic [PHASE_W-1:0] PH_TX_LOW   = 5'd14;
    localparam logic [PHASE_W-1:0] PH_RX_SETUP = 5'd15;
    localparam logic [PHASE_W-1:0] PH_RX_HIGH  = 5'd16;
    localparam logic [PHASE_W-1:0] PH_RX_HOLD  = 5'd17;
    localparam logic [PHASE_W-1:0] PH_RX_LOW   = 5'd18;

    localparam logic [CFG_W-1:0] DLY_MASK = CFG_W'((32'd1 << DELAY_BITS) - 32'd1);

    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic [BIT_IDX_W-1:0]  bit_index_reg, bit_index_next;
    logic [DELAY_BITS-1:0] delay_count_reg, delay_count_next;
    logic [BYTE_W-1:0]     shift_reg, shift_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  sda_oe_reg, sda_oe_next;
    logic                  nack_reg, nack_next;
    logic [BYTE_W-1:0]     rx_reg, rx_next;
    logic                  done;

    logic [CFG_W-1:0]      delay_masked;
    logic [DELAY_BITS-1:0] reload;
    logic [BIT_IDX_W-1:0]  bit_inc;

    // Count loaded on entry to a phase; zero delay acts as one tick
    assign delay_masked = delay_ticks & DLY_MASK;
    assign reload = (delay_masked == '0) ? '0 : DELAY_BITS'(delay_masked - CFG_W'(1));
    assign bit_inc = bit_index_reg + BIT_IDX_W'(1);

    always_comb
    begin
        phase_next       = phase_reg;
        bit_index_next   = bit_index_reg;
        delay_count_next = delay_count_reg;
        shift_next       = shift_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        sda_oe_next      = sda_oe_reg;
        nack_next        = nack_reg;
        rx_next          = rx_reg;
        done             = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (item.action != ACT_NONE && item.action <= ACT_WAIT)
            begin
                bit_index_next   = '0;
                delay_count_next = reload;
            end
            unique case (item.action)
                ACT_START:
                begin
                    sda_oe_next = 1'b1; scl_next = 1'b1; sda_next = 1'b1;
                    phase_next  = PH_ST_HIGH;
                end
                ACT_STOP:
                begin
                    sda_oe_next = 1'b1; scl_next = 1'b0; sda_next = 1'b0;
                    phase_next  = PH_SP_LOW;
                end
                ACT_WRITE:
                begin
                    sda_oe_next = 1'b1; scl_next = 1'b0; shift_next = item.tx_byte;
                    phase_next  = PH_TX_SETUP;
                end
                ACT_READ:
                begin
                    sda_oe_next = 1'b0; scl_next = 1'b0; shift_next = '0;
                    phase_next  = PH_RX_SETUP;
                end
                ACT_ACK:
                begin
                    sda_oe_next = 1'b1; scl_next = 1'b0;
                    shift_next  = {{(BYTE_W-1){1'b0}}, item.ack_level};
                    phase_next  = PH_AK_LOW;
                end
                ACT_WAIT:
                begin
                    sda_oe_next = 1'b0; scl_next = 1'b1;
                    phase_next  = PH_WA_HIGH;
                end
                default:
                begin
                end
            endcase
        end
        else if (delay_count_reg != '0)
        begin
            delay_count_next = delay_count_reg - DELAY_BITS'(1);
        end
        else
        begin
            // Phase over: most arms enter a new phase with a fresh count
            delay_count_next = reload;
            unique case (phase_reg)
                PH_ST_HIGH: begin sda_next = 1'b0; phase_next = PH_ST_LOW; end
                PH_ST_LOW:  begin scl_next = 1'b0; done = 1'b1; end
                PH_SP_LOW:  begin scl_next = 1'b1; phase_next = PH_SP_HIGH; end
                PH_SP_HIGH: begin sda_next = 1'b1; done = 1'b1; end
                PH_WA_HIGH:
                begin
                    scl_next = 1'b0;
                    if (item.sda_in)
                    begin
                        // Nack: drive a stop sequence
                        nack_next   = 1'b1;
                        sda_oe_next = 1'b1;
                        sda_next    = 1'b0;
                        phase_next  = PH_WS_LOW;
                    end
                    else
                    begin
                        nack_next  = 1'b0;
                        phase_next = PH_WA_LOW;
                    end
                end
                PH_WS_LOW:  begin scl_next = 1'b1; phase_next = PH_WS_HIGH; end
                PH_WS_HIGH:
                begin
                    sda_next = 1'b1; scl_next = 1'b0; phase_next = PH_WA_LOW;
                end
                PH_WA_LOW:  done = 1'b1;
                PH_AK_LOW:
                begin
                    sda_next = shift_reg[0]; scl_next = 1'b1; phase_next = PH_AK_HIGH;
                end
                PH_AK_HIGH: begin scl_next = 1'b0; done = 1'b1; end
                PH_TX_SETUP:
                begin
                    sda_next   = shift_reg[MSB_POS];
                    shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                    phase_next = PH_TX_DATA;
                end
                PH_TX_DATA: begin scl_next = 1'b1; phase_next = PH_TX_HIGH; end
                PH_TX_HIGH: begin scl_next = 1'b0; phase_next = PH_TX_LOW; end
                PH_TX_LOW:
                begin
                    bit_index_next = bit_inc;
                    if (bit_inc >= BITS_PER_BYTE)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        sda_next   = shift_reg[MSB_POS];
                        shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                        phase_next = PH_TX_DATA;
                    end
                end
                PH_RX_SETUP: begin scl_next = 1'b1; phase_next = PH_RX_HIGH; end
                PH_RX_HIGH:
                begin
                    shift_next = {shift_reg[BYTE_W-2:0], item.sda_in};
                    phase_next = PH_RX_HOLD;
                end
                PH_RX_HOLD: begin scl_next = 1'b0; phase_next = PH_RX_LOW; end
                PH_RX_LOW:
                begin
                    bit_index_next = bit_inc;
                    if (bit_inc >= BITS_PER_BYTE)
                    begin
                        rx_next = shift_reg;
                        done    = 1'b1;
                    end
                    else
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_RX_HIGH;
                    end
                end
                default: done = 1'b1;
            endcase
            if (done)
            begin
                phase_next       = PH_IDLE;
                delay_count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_index_reg   <= '0;
            delay_count_reg <= '0;
            shift_reg       <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            sda_oe_reg      <= 1'b1;
            nack_reg        <= 1'b0;
            rx_reg          <= '0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            bit_index_reg   <= bit_index_next;
            delay_count_reg <= delay_count_next;
            shift_reg       <= shift_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            sda_oe_reg      <= sda_oe_next;
            nack_reg        <= nack_next;
            rx_reg          <= rx_next;
        end
    end

    // Result reflects the state after this tick
    assign result.scl_level         = scl_next;
    assign result.sda_level         = sda_next;
    assign result.sda_output_enable = sda_oe_next;
    assign result.busy_res          = (phase_next != PH_IDLE);
    assign result.done_res          = done;
    assign result.rx_byte           = rx_next;
    assign result.nack_seen         = nack_next;

endmodule

// File: hdl/i2cmbe_cfg.sv
// APB register file holding the delay phase length.
module i2cmbe_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [1:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [i2cmbe_pkg::CFG_W-1:0] delay_ticks
);
    import i2cmbe_pkg::*;

    localparam logic [1:0] ADDR_DELAY = 2'd0;

    logic [CFG_W-1:0] delay_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_DELAY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
        end
        else if (wr_en)
        begin
            delay_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata      = (paddr == ADDR_DELAY) ? {{(32-CFG_W){1'b0}}, delay_reg} : '0;
    assign delay_ticks = delay_reg;

endmodule

// File: hdl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: stream ports, item and result registers.
//
// Each input beat on the s_ group is one tick of the pin sequencer and may
// carry a command (start, stop, write byte, read byte, send ack, wait ack).
// Commands that arrive while busy_res is high are dropped. Every input beat
// yields exactly one result beat on the m_ group: the SCL, SDA and SDA enable
// levels after that tick, busy, a done pulse, the last received byte and the
// nack flag.
// An input beat is held in the item register, then the sequencer step lands
// in the result register.
// Throughput is one beat per cycle while m_tready stays high; the next item
// enters while a finished result still waits to be taken.
// When m_tready is low the result register holds, the item register fills,
// and s_tready drops until the result is taken; no tick is lost.
// Reset leaves the engine idle with SCL, SDA and the SDA enable high, and
// the delay register at 250 ticks. Write delay_ticks at byte address 0 of
// the APB port only while the engine is idle; it is masked to DELAY_BITS.
module i2c_master_bit_engine #(
    parameter int DELAY_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    // action[2:0], tx_byte[10:3], ack_level[11], sda_in[12], zero pad
    input  logic [15:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // scl_level[0], sda_level[1], sda_output_enable[2], busy_res[3],
    // done_res[4], rx_byte[12:5], nack_seen[13], zero pad
    output logic [15:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2cmbe_pkg::*;

    localparam int ITEM_W = $bits(item_t);
    localparam int RES_W  = $bits(result_t);

    logic             in_valid_reg;
    item_t            in_item_reg;
    logic             out_valid_reg;
    result_t          out_res_reg;
    logic             advance;
    result_t          step_res;
    logic [CFG_W-1:0] delay_ticks;

    // Move the held item through the sequencer when the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= item_t'(s_tdata[ITEM_W-1:0]);
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    i2cmbe_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .delay_ticks (delay_ticks)
    );

    i2cmbe_seq #(
        .DELAY_BITS (DELAY_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .delay_ticks (delay_ticks),
        .item        (in_item_reg),
        .result      (step_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, out_res_reg};

endmodule
